// ===== rtl/core/hvn_pkg.sv =====
`default_nettype none
package hvn_pkg;

	// Largest map side; the store is addressed as row * MAX_MAP_SIZE + column.
	localparam int MAX_MAP_SIZE = 64;
	localparam int COORD_W      = 6;
	localparam int ADDR_W       = 2 * COORD_W;
	localparam int STORE_DEPTH  = MAX_MAP_SIZE * MAX_MAP_SIZE;

	localparam int RAD_W  = 34;  // sum of three 16-bit squares
	localparam int ROOT_W = 31;  // floor(sqrt(sum * 2^28))
	localparam int NUM_W  = 45;  // (mag << 28) + root / 2
	localparam int QUOT_W = 16;

	typedef enum logic [1:0] {
		CFG_MAP_SIZE    = 2'd0,
		CFG_HORIZ_SCALE = 2'd1,
		CFG_VERT_SCALE  = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [15:0]       mul_a;
		logic [15:0]       mul_b;
		logic              start_sqrt;
		logic              start_div;
		logic [RAD_W-1:0]  radicand;
		logic [NUM_W-1:0]  num;
		logic [ROOT_W-1:0] den;
	} arith_req_t;

	typedef struct packed {
		logic              busy;
		logic [31:0]       prod;
		logic [ROOT_W-1:0] root;
		logic [QUOT_W-1:0] quot;
	} arith_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/hvn_store.sv =====
`default_nettype none
module hvn_store (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [hvn_pkg::ADDR_W-1:0] waddr,
	input  wire logic [7:0]                wdata,
	input  wire logic [hvn_pkg::ADDR_W-1:0] raddr,
	output logic      [7:0]                rdata
);

	logic [7:0] mem [hvn_pkg::STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/core/hvn_arith.sv =====
`default_nettype none
module hvn_arith (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire hvn_pkg::arith_req_t req,
	output hvn_pkg::arith_rsp_t      rsp
);

	typedef enum logic [1:0] {
		M_IDLE,
		M_SQRT,
		M_DIV
	} mode_t;

	mode_t                       mode_q;
	logic [4:0]                  cnt_q;
	logic [32:0]                 rem_q;
	logic [hvn_pkg::ROOT_W-1:0]  res_q;
	logic [61:0]                 rad_q;
	logic [15:0]                 nlo_q;
	logic [hvn_pkg::ROOT_W-1:0]  den_q;
	logic [31:0]                 prod_q;

	logic [34:0] wa;
	logic [34:0] wb;
	logic [35:0] diff;
	logic        ge;
	logic [34:0] rem_n;

	// One subtract-compare serves both the root and the divide recurrences.
	always_comb begin
		if (mode_q == M_SQRT) begin
			wa = {rem_q, rad_q[61:60]};
			wb = {2'b00, res_q, 2'b01};
		end else begin
			wa = {1'b0, rem_q, nlo_q[15]};
			wb = {4'b0000, den_q};
		end
		diff  = {1'b0, wa} - {1'b0, wb};
		ge    = ~diff[35];
		rem_n = ge ? diff[34:0] : wa;
	end

	always_ff @(posedge clk) begin
		prod_q <= req.mul_a * req.mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			cnt_q  <= '0;
		end else begin
			unique case (mode_q)
				M_IDLE: begin
					if (req.start_sqrt) begin
						mode_q <= M_SQRT;
						cnt_q  <= 5'(hvn_pkg::ROOT_W - 1);
						rem_q  <= '0;
						res_q  <= '0;
						rad_q  <= {req.radicand, 28'b0};
					end else if (req.start_div) begin
						mode_q <= M_DIV;
						cnt_q  <= 5'(hvn_pkg::QUOT_W - 1);
						rem_q  <= {4'b0000, req.num[hvn_pkg::NUM_W-1:16]};
						nlo_q  <= req.num[15:0];
						den_q  <= req.den;
						res_q  <= '0;
					end
				end
				M_SQRT, M_DIV: begin
					rem_q <= rem_n[32:0];
					res_q <= {res_q[hvn_pkg::ROOT_W-2:0], ge};
					rad_q <= {rad_q[59:0], 2'b00};
					nlo_q <= {nlo_q[14:0], 1'b0};
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						mode_q <= M_IDLE;
					end
				end
				default: mode_q <= M_IDLE;
			endcase
		end
	end

	assign rsp.busy = (mode_q != M_IDLE);
	assign rsp.prod = prod_q;
	assign rsp.root = res_q;
	assign rsp.quot = res_q[hvn_pkg::QUOT_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/heightmap_vertex_normal_unit.sv =====
`default_nettype none
// Heightmap vertex/normal unit. Holds a 64x64 map of 8-bit height samples and
// answers vertex queries. A transaction is accepted when start is high while
// busy is low. A write (action 0) stores one sample in that cycle, gives no
// result and leaves the unit ready at once. A query (action 1) raises busy and
// ends with done high for exactly one cycle carrying the position (Q14.8 x and z, Q8.8 y) and
// the unit normal (Q1.14) of the vertex; the receiver cannot stall, so capture
// the result in the cycle done is high. A query outside map_size goes straight
// to the output state and is answered with valid_res low and zero fields. An
// in-range query runs five sample reads through the single store read port,
// six multiplier products and up to nine normalizing shifts, then the shared
// subtract unit runs a 31-step square root and four 16-step
// divisions. Write configuration through cfg_valid/cfg_ready only while busy
// is low; cfg_ready is always high and indexes beyond the list are ignored.
module heightmap_vertex_normal_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        action,
	input  wire logic [5:0]  column,
	input  wire logic [5:0]  row,
	input  wire logic [7:0]  height,
	output logic             done,
	output logic             valid_res,
	output logic [21:0]      pos_x,
	output logic [15:0]      pos_y,
	output logic [21:0]      pos_z,
	output logic signed [15:0] norm_x,
	output logic [14:0]      norm_y,
	output logic signed [15:0] norm_z,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_MUL,
		S_SHIFT,
		S_SQ,
		S_SQRT,
		S_SQRT_WAIT,
		S_DIV,
		S_DIV_WAIT,
		S_OUT
	} state_t;

	state_t      state_q;
	logic [2:0]  step_q;

	logic [6:0]  map_size_q;
	logic [15:0] horiz_q;
	logic [15:0] vert_q;

	logic [5:0]  col_q;
	logic [5:0]  row_q;
	logic [6:0]  ms_q;
	logic        vld_q;
	logic [7:0]  hs_q [5];
	logic [24:0] mx_q, my_q, mz_q;
	logic [21:0] px_q, pz_q;
	logic [23:0] hv_q;
	logic [33:0] s_q;
	logic [hvn_pkg::ROOT_W-1:0] len_q;
	logic [15:0] qy_q, nx_q, ny_q, nz_q;

	hvn_pkg::arith_req_t req;
	hvn_pkg::arith_rsp_t rsp;

	logic                      we;
	logic [hvn_pkg::ADDR_W-1:0] raddr;
	logic [7:0]                rdata;

	// Clamped neighbour coordinates.
	logic [5:0] lx, gx, lz, gz;
	logic [6:0] ms_in;
	logic [7:0] dxa, dza;
	logic       negx, negz;
	logic [15:0] mag;

	assign ms_in = (map_size_q > 7'(hvn_pkg::MAX_MAP_SIZE)) ?
		7'(hvn_pkg::MAX_MAP_SIZE) : map_size_q;

	always_comb begin
		lx = (col_q != 6'd0) ? col_q - 6'd1 : col_q;
		lz = (row_q != 6'd0) ? row_q - 6'd1 : row_q;
		gx = ({1'b0, col_q} + 7'd1 < ms_q) ? col_q + 6'd1 : col_q;
		gz = ({1'b0, row_q} + 7'd1 < ms_q) ? row_q + 6'd1 : row_q;
		negx = hs_q[1] > hs_q[0];
		negz = hs_q[3] > hs_q[2];
		dxa = negx ? hs_q[1] - hs_q[0] : hs_q[0] - hs_q[1];
		dza = negz ? hs_q[3] - hs_q[2] : hs_q[2] - hs_q[3];
	end

	// Store read address by read step: left, right, up, down, center.
	always_comb begin
		unique case (step_q)
			3'd0:    raddr = {row_q, lx};
			3'd1:    raddr = {row_q, gx};
			3'd2:    raddr = {lz, col_q};
			3'd3:    raddr = {gz, col_q};
			default: raddr = {row_q, col_q};
		endcase
	end

	assign we = start && !busy && !action;

	hvn_store u_store (
		.clk   (clk),
		.we    (we),
		.waddr ({row, column}),
		.wdata (height),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		unique case (step_q)
			3'd1:    mag = mx_q[15:0];
			3'd2:    mag = my_q[15:0];
			default: mag = mz_q[15:0];
		endcase
	end

	// Operand selection for the shared unit.
	always_comb begin
		req = '0;
		if (state_q == S_MUL) begin
			unique case (step_q)
				3'd0:    begin req.mul_a = {8'd0, dxa};     req.mul_b = vert_q;  end
				3'd1:    begin req.mul_a = {8'd0, dza};     req.mul_b = vert_q;  end
				3'd2:    begin req.mul_a = 16'd510;         req.mul_b = horiz_q; end
				3'd3:    begin req.mul_a = {10'd0, col_q};  req.mul_b = horiz_q; end
				3'd4:    begin req.mul_a = {10'd0, row_q};  req.mul_b = horiz_q; end
				default: begin req.mul_a = {8'd0, hs_q[4]}; req.mul_b = vert_q;  end
			endcase
		end else if (state_q == S_SQ) begin
			unique case (step_q)
				3'd0:    begin req.mul_a = mx_q[15:0]; req.mul_b = mx_q[15:0]; end
				3'd1:    begin req.mul_a = my_q[15:0]; req.mul_b = my_q[15:0]; end
				default: begin req.mul_a = mz_q[15:0]; req.mul_b = mz_q[15:0]; end
			endcase
		end
		req.start_sqrt = (state_q == S_SQRT);
		req.radicand   = s_q;
		req.start_div  = (state_q == S_DIV);
		if (step_q == 3'd0) begin
			req.num = hvn_pkg::NUM_W'(hv_q) + hvn_pkg::NUM_W'(127);
			req.den = hvn_pkg::ROOT_W'(255);
		end else begin
			req.num = {1'b0, mag, 28'd0} + hvn_pkg::NUM_W'(len_q[hvn_pkg::ROOT_W-1:1]);
			req.den = len_q;
		end
	end

	hvn_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_size_q <= 7'd32;
			horiz_q    <= 16'd512;
			vert_q     <= 16'd2560;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hvn_pkg::CFG_MAP_SIZE:    map_size_q <= cfg_data[6:0];
				hvn_pkg::CFG_HORIZ_SCALE: horiz_q    <= cfg_data;
				hvn_pkg::CFG_VERT_SCALE:  vert_q     <= cfg_data;
				default:                  ;
			endcase
		end
	end

	// Sequencer and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start && action) begin
						col_q  <= column;
						row_q  <= row;
						ms_q   <= ms_in;
						step_q <= '0;
						if ({1'b0, column} >= ms_in || {1'b0, row} >= ms_in) begin
							vld_q   <= 1'b0;
							state_q <= S_OUT;
						end else begin
							vld_q   <= 1'b1;
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					// Issue one address, capture the sample of the previous one.
					if (step_q != 3'd0) begin
						hs_q[step_q - 3'd1] <= rdata;
					end
					if (step_q == 3'd5) begin
						step_q  <= '0;
						state_q <= S_MUL;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_MUL: begin
					unique case (step_q)
						3'd1:    mx_q <= rsp.prod[24:0];
						3'd2:    mz_q <= rsp.prod[24:0];
						3'd3:    my_q <= rsp.prod[24:0];
						3'd4:    px_q <= rsp.prod[21:0];
						3'd5:    pz_q <= rsp.prod[21:0];
						3'd6:    hv_q <= rsp.prod[23:0];
						default: ;
					endcase
					if (step_q == 3'd6) begin
						step_q <= '0;
						if ((mx_q | my_q | mz_q) == 25'd0) begin
							vld_q   <= 1'b0;
							state_q <= S_OUT;
						end else begin
							state_q <= S_SHIFT;
						end
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_SHIFT: begin
					// Halve all three together until each fits in 16 bits.
					if ((mx_q[24:16] | my_q[24:16] | mz_q[24:16]) != 9'd0) begin
						mx_q <= mx_q >> 1;
						my_q <= my_q >> 1;
						mz_q <= mz_q >> 1;
					end else begin
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (step_q == 3'd1) begin
						s_q <= 34'(rsp.prod);
					end else if (step_q != 3'd0) begin
						s_q <= s_q + 34'(rsp.prod);
					end
					if (step_q == 3'd3) begin
						step_q  <= '0;
						state_q <= S_SQRT;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_SQRT: state_q <= S_SQRT_WAIT;
				S_SQRT_WAIT: begin
					if (!rsp.busy) begin
						len_q   <= rsp.root;
						state_q <= S_DIV;
					end
				end
				S_DIV: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (!rsp.busy) begin
						unique case (step_q)
							3'd0:    qy_q <= rsp.quot;
							3'd1:    nx_q <= rsp.quot;
							3'd2:    ny_q <= rsp.quot;
							default: nz_q <= rsp.quot;
						endcase
						if (step_q == 3'd3) begin
							state_q <= S_OUT;
						end else begin
							step_q  <= step_q + 3'd1;
							state_q <= S_DIV;
						end
					end
				end
				S_OUT: begin
					done      <= 1'b1;
					valid_res <= vld_q;
					if (vld_q) begin
						pos_x  <= px_q;
						pos_y  <= qy_q;
						pos_z  <= pz_q;
						norm_x <= negx ? -$signed(nx_q) : $signed(nx_q);
						norm_y <= ny_q[14:0];
						norm_z <= negz ? -$signed(nz_q) : $signed(nz_q);
					end else begin
						pos_x  <= '0;
						pos_y  <= '0;
						pos_z  <= '0;
						norm_x <= '0;
						norm_y <= '0;
						norm_z <= '0;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
